// ===== src/rsflq_pkg.sv =====
// ----------------------------------------------------------------------------
// rsflq_pkg
// shared types and codes for the receive sequence filter and link quality unit
// ----------------------------------------------------------------------------
package rsflq_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    // event kinds carried in s_tuser
    localparam logic [1:0] KIND_FRAME    = 2'd0;
    localparam logic [1:0] KIND_TX_ACK   = 2'd1;
    localparam logic [1:0] KIND_TX_RETRY = 2'd2;
    localparam logic [1:0] KIND_REPORT   = 2'd3;

    // frame types
    localparam logic [2:0] FT_ACK      = 3'd0;
    localparam logic [2:0] FT_NO_ACK   = 3'd1;
    localparam logic [2:0] FT_LOW_LAT  = 3'd2;
    localparam logic [2:0] FT_WITH_ACK = 3'd3;

    // delivery classes
    localparam logic [1:0] CLS_INVALID   = 2'd0;
    localparam logic [1:0] CLS_NON_ACK   = 2'd1;
    localparam logic [1:0] CLS_HIGH_PRIO = 2'd2;
    localparam logic [1:0] CLS_ACK_BUF   = 2'd3;

    // configuration register indexes
    localparam logic CFG_ACK_ID_OFFSET = 1'b0;
    localparam logic CFG_WRAP_WINDOW   = 1'b1;

    localparam logic [7:0] ACK_ID_OFFSET_RESET = 8'd0;
    localparam logic [6:0] WRAP_WINDOW_RESET   = 7'd10;

    // sequence handling
    localparam logic [7:0]        SEQ_RESET = 8'hFF;
    localparam logic signed [9:0] SEQ_SPAN  = 10'sd256;

    // report arithmetic
    localparam int         PCT_SCALE = 100;
    localparam logic [7:0] PCT_NONE  = 8'hFF;
    localparam int         QUOT_W    = 7;
    localparam int         STEP_W    = 3;

    // report divisions, in order
    localparam logic [1:0] RPT_TX  = 2'd0;
    localparam logic [1:0] RPT_RX  = 2'd1;
    localparam logic [1:0] RPT_USE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_REPORT
    } lq_state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/rx_sequence_filter_link_quality_unit.sv =====
// ----------------------------------------------------------------------------
// rx_sequence_filter_link_quality_unit
// per-channel sequence filter with duplicate counting and link quality report
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  cfg      | in        | cfg_we, cfg_index, cfg_data (register write)
//  s_*      | in        | event: kind in tuser, frame header in tdata
//  m_*      | out       | frame verdict or report, report flag in tuser
//
//  a frame transaction first does the registered sequence table read, then the
//  compare, counter update and table write-back
//  ack and retry events give no result
//  a report tick runs three divisions on the shared restoring divider, between
//  the accept and the output
//  reset clears the table valid bits at once, so no clearing pass is needed
//  a held result blocks only the next result; input stalls wait for it
// ----------------------------------------------------------------------------
module rx_sequence_filter_link_quality_unit
    import rsflq_pkg::*;
#(
    parameter int CHANNELS    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // frame_type, channel_id, frame_seq, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // deliver, deliver_class, ack_req, ack_channel, ack_header_seq,
    // acked_seq, tx_link_pct, rx_link_pct, rx_used_pct, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // report_valid
    output logic [0:0]           m_tuser
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = COUNT_WIDTH;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [7:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {{(CW - 7){1'b0}}, b};
        sat_add = s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    lq_state_t state_reg, state_next;

    logic [7:0]    ack_id_offset_reg;
    logic [6:0]    wrap_window_reg;
    logic [7:0]    ack_seq_reg, ack_seq_next;
    logic [CW-1:0] ack_cnt_reg, ack_cnt_next;
    logic [CW-1:0] retry_cnt_reg, retry_cnt_next;
    logic [CW-1:0] useful_cnt_reg, useful_cnt_next;
    logic [CW-1:0] useless_cnt_reg, useless_cnt_next;
    logic [CW-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CHANNELS-1:0] valid_reg;
    logic [1:0]    rpt_idx_reg;
    logic [7:0]    tx_pct_reg, rx_pct_reg, use_pct_reg;

    logic [2:0]    ftype_reg;
    logic [7:0]    chan_reg, seq_reg;
    logic [IW-1:0] idx_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_user_reg;

    logic [1:0]    in_kind;
    logic [2:0]    in_ftype;
    logic [7:0]    in_chan, in_seq;
    logic [IW-1:0] in_idx;
    logic          in_acc;
    logic          out_free;

    logic frame_commit, report_commit;
    logic ram_we;
    logic [7:0] ram_rdata;

    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;
    logic [CW:0]           div_num;
    logic [CW+1:0]         div_den;
    logic [QUOT_W-1:0]     div_quot;
    logic [CW:0]           recv_sum;
    logic                  den_zero;
    logic [7:0]            pct_val;

    logic [7:0]            stored;
    logic signed [9:0]     raw, fwd_dist, neg_win;
    logic                  wrap, is_new, store, deliver, ack_req;
    logic [7:0]            miss_inc;
    logic [1:0]            dclass;
    logic [7:0]            ack_channel, ack_header_seq, acked_seq;
    logic [M_TDATA_W-1:0]  frame_data, report_data;

    assign in_kind  = s_tuser;
    assign in_ftype = s_tdata[2:0];
    assign in_chan  = s_tdata[10:3];
    assign in_seq   = s_tdata[18:11];
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // channel modulo table depth by conditional subtraction
    always_comb
    begin
        logic [15:0] v;
        v = 16'(in_chan);
        for (int k = 7; k >= 0; k--)
        begin
            if (v >= (16'(CHANNELS) << k))
            begin
                v = v - (16'(CHANNELS) << k);
            end
        end
        in_idx = v[IW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_kind == KIND_FRAME)
                begin
                    state_next = ST_LOOKUP;
                end
                else if (in_acc && in_kind == KIND_REPORT)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = (rpt_idx_reg == RPT_USE) ? ST_REPORT : ST_DIV_START;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready       = 1'b0;
        frame_commit   = 1'b0;
        report_commit  = 1'b0;
        div_ctrl.start = 1'b0;
        case (state_reg)
            ST_IDLE:      s_tready       = 1'b1;
            ST_LOOKUP:    frame_commit   = out_free;
            ST_DIV_START: div_ctrl.start = 1'b1;
            ST_REPORT:    report_commit  = out_free;
            default:      s_tready       = 1'b0;
        endcase
    end

    // frame verdict from the stored sequence
    always_comb
    begin
        stored   = valid_reg[idx_reg] ? ram_rdata : SEQ_RESET;
        raw      = $signed({2'b00, seq_reg}) - $signed({2'b00, stored});
        neg_win  = -$signed({3'b000, wrap_window_reg});
        wrap     = raw < neg_win;
        fwd_dist = wrap ? raw + SEQ_SPAN : raw;
        is_new   = fwd_dist > 10'sd0;
        miss_inc = is_new ? fwd_dist[7:0] - 8'd1 : 8'd0;
        store    = (ftype_reg == FT_ACK) || is_new;
        deliver  = is_new && (ftype_reg != FT_ACK);
        ack_req  = ftype_reg == FT_WITH_ACK;
        case (ftype_reg)
            FT_NO_ACK:   dclass = CLS_NON_ACK;
            FT_LOW_LAT:  dclass = CLS_HIGH_PRIO;
            FT_WITH_ACK: dclass = CLS_ACK_BUF;
            default:     dclass = CLS_INVALID;
        endcase
        if (!deliver)
        begin
            dclass = CLS_INVALID;
        end
        ack_channel    = ack_req ? chan_reg + ack_id_offset_reg : 8'd0;
        ack_header_seq = ack_req ? ack_seq_reg : 8'd0;
        acked_seq      = ack_req ? seq_reg : 8'd0;
        frame_data = {28'd0, acked_seq, ack_header_seq, ack_channel, ack_req, dclass,
                      deliver};
        report_data = {4'd0, use_pct_reg, rx_pct_reg, tx_pct_reg, 28'd0};
    end

    assign ram_we = frame_commit && store;

    // report division operands
    always_comb
    begin
        recv_sum = {1'b0, useful_cnt_reg} + {1'b0, useless_cnt_reg};
        case (rpt_idx_reg)
            RPT_TX:
            begin
                div_num = {1'b0, ack_cnt_reg};
                div_den = {2'b00, ack_cnt_reg} + {2'b00, retry_cnt_reg};
            end
            RPT_RX:
            begin
                div_num = recv_sum;
                div_den = {2'b00, miss_cnt_reg} + {1'b0, recv_sum};
            end
            RPT_USE:
            begin
                div_num = {1'b0, useful_cnt_reg};
                div_den = {1'b0, recv_sum};
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
        den_zero = div_den == '0;
        pct_val  = den_zero ? PCT_NONE : {1'b0, div_quot};
    end

    // counters and ack sequence
    always_comb
    begin
        ack_cnt_next     = ack_cnt_reg;
        retry_cnt_next   = retry_cnt_reg;
        useful_cnt_next  = useful_cnt_reg;
        useless_cnt_next = useless_cnt_reg;
        miss_cnt_next    = miss_cnt_reg;
        ack_seq_next     = ack_seq_reg;
        if (in_acc && in_kind == KIND_TX_ACK)
        begin
            ack_cnt_next = sat_add(ack_cnt_reg, 8'd1);
        end
        if (in_acc && in_kind == KIND_TX_RETRY)
        begin
            retry_cnt_next = sat_add(retry_cnt_reg, 8'd1);
        end
        if (frame_commit)
        begin
            miss_cnt_next = sat_add(miss_cnt_reg, miss_inc);
            if (is_new)
            begin
                useful_cnt_next = sat_add(useful_cnt_reg, 8'd1);
            end
            else
            begin
                useless_cnt_next = sat_add(useless_cnt_reg, 8'd1);
            end
            if (ack_req)
            begin
                ack_seq_next = ack_seq_reg + 8'd1;
            end
        end
        if (report_commit)
        begin
            ack_cnt_next     = '0;
            retry_cnt_next   = '0;
            useful_cnt_next  = '0;
            useless_cnt_next = '0;
            miss_cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ack_id_offset_reg <= ACK_ID_OFFSET_RESET;
            wrap_window_reg   <= WRAP_WINDOW_RESET;
            ack_seq_reg       <= '0;
            ack_cnt_reg       <= '0;
            retry_cnt_reg     <= '0;
            useful_cnt_reg    <= '0;
            useless_cnt_reg   <= '0;
            miss_cnt_reg      <= '0;
            valid_reg         <= '0;
            rpt_idx_reg       <= RPT_TX;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ack_seq_reg     <= ack_seq_next;
            ack_cnt_reg     <= ack_cnt_next;
            retry_cnt_reg   <= retry_cnt_next;
            useful_cnt_reg  <= useful_cnt_next;
            useless_cnt_reg <= useless_cnt_next;
            miss_cnt_reg    <= miss_cnt_next;
            if (cfg_we && cfg_index == CFG_ACK_ID_OFFSET)
            begin
                ack_id_offset_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_WRAP_WINDOW)
            begin
                wrap_window_reg <= cfg_data[6:0];
            end
            if (ram_we)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (report_commit)
            begin
                rpt_idx_reg <= RPT_TX;
            end
            else if (div_stat.done)
            begin
                rpt_idx_reg <= rpt_idx_reg + 2'd1;
            end
            if (frame_commit || report_commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ftype_reg <= in_ftype;
            chan_reg  <= in_chan;
            seq_reg   <= in_seq;
            idx_reg   <= in_idx;
        end
        if (div_stat.done)
        begin
            case (rpt_idx_reg)
                RPT_TX:  tx_pct_reg  <= pct_val;
                RPT_RX:  rx_pct_reg  <= pct_val;
                default: use_pct_reg <= pct_val;
            endcase
        end
        if (frame_commit)
        begin
            out_data_reg <= frame_data;
            out_user_reg <= 1'b0;
        end
        else if (report_commit)
        begin
            out_data_reg <= report_data;
            out_user_reg <= 1'b1;
        end
    end

    rsflq_ram #(
        .WIDTH (8),
        .DEPTH (CHANNELS)
    ) u_seq_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (seq_reg),
        .re    (in_acc),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    rsflq_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a zero divisor leaves the quotient meaningless, it is replaced downstream
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.done && !den_zero) |-> div_quot <= QUOT_W'(PCT_SCALE))
        else $error("percentage above full scale");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        report_commit |=> (ack_cnt_reg == '0 && retry_cnt_reg == '0 &&
                           useful_cnt_reg == '0 && useless_cnt_reg == '0 &&
                           miss_cnt_reg == '0))
        else $error("counters not cleared after report");

    a_count_events_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_kind == KIND_TX_ACK || in_kind == KIND_TX_RETRY)) |=> s_tready)
        else $error("ack or retry event did not complete in one cycle");

endmodule

// ===== src/rsflq_ram.sv =====
// ----------------------------------------------------------------------------
// rsflq_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module rsflq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rsflq_div.sv =====
// ----------------------------------------------------------------------------
// rsflq_div
// iterative restoring divider for percentages: quot = num * 100 / den
// ----------------------------------------------------------------------------
module rsflq_div
    import rsflq_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_ctrl_t               ctrl,
    input  logic [COUNT_WIDTH:0]    num,
    input  logic [COUNT_WIDTH+1:0]  den,
    output div_stat_t               stat,
    output logic [QUOT_W-1:0]       quot
);

    localparam int WW = COUNT_WIDTH + 8;

    logic [WW-1:0]     rem_reg, rem_next;
    logic [WW-1:0]     dsh_reg, dsh_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WW-1:0]     num_ext;
    logic [WW:0]       trial;

    assign num_ext = WW'(num);
    assign trial   = {1'b0, rem_reg} - {1'b0, dsh_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            // times 100 as 64 + 32 + 4
            rem_next  = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
            dsh_next  = WW'(den) << (QUOT_W - 1);
            quot_next = '0;
            step_next = STEP_W'(QUOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WW])
            begin
                rem_next = trial[WW-1:0];
            end
            quot_next = {quot_reg[QUOT_W-2:0], ~trial[WW]};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ===== verif/rx_seq_filter_checker.sv =====
// ----------------------------------------------------------------------------
// rx_seq_filter_checker
// watches the event and verdict streams, keeps its own copy of the sequence
// table and link counters, and compares every verdict with the predicted one
// ----------------------------------------------------------------------------
module rx_seq_filter_checker
    import rsflq_pkg::*;
#(
    parameter int CHANNELS    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // frame_type, channel_id, frame_seq, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // deliver, deliver_class, ack_req, ack_channel, ack_header_seq,
    // acked_seq, tx_link_pct, rx_link_pct, rx_used_pct, zero pad
    input  logic [M_TDATA_W-1:0] m_tdata,
    // report_valid
    input  logic [0:0]           m_tuser,
    output int                   fail_count,
    output int                   pending
);

    localparam longint unsigned CNT_MAX     = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam int              PRINT_LIMIT = 40;

    typedef struct packed {
        logic       deliver;
        logic [1:0] cls;
        logic       ack_req;
        logic [7:0] ack_chan;
        logic [7:0] ack_hseq;
        logic [7:0] acked;
        logic       rpt;
        logic [7:0] tx_q;
        logic [7:0] rx_q;
        logic [7:0] use_q;
    } verdict_t;

    verdict_t        verdict_q[$];
    logic [7:0]      seq_tab [CHANNELS];
    logic [7:0]      ack_hseq_ctr;
    longint unsigned acks;
    longint unsigned retries;
    longint unsigned useful;
    longint unsigned useless;
    longint unsigned missed;
    logic [7:0]      ack_ofs;
    logic [6:0]      wrap_win;
    int              result_no;

    function automatic longint unsigned sat_add(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > CNT_MAX) ? CNT_MAX : s;
    endfunction

    function automatic logic [7:0] percent(input longint unsigned num,
                                           input longint unsigned den);
        longint unsigned q;
        if (den == 0)
            return PCT_NONE;
        q = (num * PCT_SCALE) / den;
        return q[7:0];
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("verdict %0d %s got %0h expected %0h",
                                      result_no, name, got, want));
    endtask

    task automatic predict_verdict(input logic [1:0] kind, input logic [2:0] ft,
                                   input logic [7:0] ch, input logic [7:0] sq,
                                   output bit has, output verdict_t v);
        int              idx;
        int              raw;
        int              win;
        int              d;
        longint unsigned recv;
        v   = '0;
        has = 1'b1;
        case (kind)
            KIND_TX_ACK:
            begin
                acks = sat_add(acks, 64'd1);
                has  = 1'b0;
            end
            KIND_TX_RETRY:
            begin
                retries = sat_add(retries, 64'd1);
                has     = 1'b0;
            end
            KIND_REPORT:
            begin
                recv    = useful + useless;
                v.rpt   = 1'b1;
                v.tx_q  = percent(acks, acks + retries);
                v.rx_q  = percent(recv, missed + recv);
                v.use_q = percent(useful, recv);
                acks    = 0;
                retries = 0;
                useful  = 0;
                useless = 0;
                missed  = 0;
            end
            default:
            begin
                idx = ch % CHANNELS;
                raw = int'(sq) - int'(seq_tab[idx]);
                win = int'(wrap_win);
                // far enough behind counts as wrapped round
                d   = (raw < -win) ? raw + int'(SEQ_SPAN) : raw;
                if (d > 0)
                begin
                    missed = sat_add(missed, 64'(d - 1));
                    useful = sat_add(useful, 64'd1);
                end
                else
                begin
                    useless = sat_add(useless, 64'd1);
                end
                if (ft == FT_ACK)
                begin
                    seq_tab[idx] = sq;
                end
                else
                begin
                    // duplicates of with-ack frames are still acked
                    if (ft == FT_WITH_ACK)
                    begin
                        v.ack_req    = 1'b1;
                        v.ack_chan   = ch + ack_ofs;
                        v.ack_hseq   = ack_hseq_ctr;
                        v.acked      = sq;
                        ack_hseq_ctr = ack_hseq_ctr + 8'd1;
                    end
                    if (raw > 0 || raw < -win)
                    begin
                        seq_tab[idx] = sq;
                        v.deliver    = 1'b1;
                        case (ft)
                            FT_NO_ACK:   v.cls = CLS_NON_ACK;
                            FT_LOW_LAT:  v.cls = CLS_HIGH_PRIO;
                            FT_WITH_ACK: v.cls = CLS_ACK_BUF;
                            default:     v.cls = CLS_INVALID;
                        endcase
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        verdict_t next_v;
        bit       has;
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                seq_tab[i] = SEQ_RESET;
            ack_hseq_ctr = '0;
            acks         = 0;
            retries      = 0;
            useful       = 0;
            useless      = 0;
            missed       = 0;
            ack_ofs      = ACK_ID_OFFSET_RESET;
            wrap_win     = WRAP_WINDOW_RESET;
            verdict_q.delete();
            pending      = 0;
        end
        else
        begin
            // verdicts out first: one leaving now cannot belong to an event entering now
            if (m_tvalid && m_tready)
            begin
                result_no++;
                if (verdict_q.size() == 0)
                begin
                    report_mismatch($sformatf("verdict %0d arrived with none expected",
                                              result_no));
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("deliver", 8'(m_tdata[0]), 8'(want.deliver));
                    check_field("deliver_class", 8'(m_tdata[2:1]), 8'(want.cls));
                    check_field("ack_req", 8'(m_tdata[3]), 8'(want.ack_req));
                    check_field("ack_channel", m_tdata[11:4], want.ack_chan);
                    check_field("ack_header_seq", m_tdata[19:12], want.ack_hseq);
                    check_field("acked_seq", m_tdata[27:20], want.acked);
                    check_field("tx_link_pct", m_tdata[35:28], want.tx_q);
                    check_field("rx_link_pct", m_tdata[43:36], want.rx_q);
                    check_field("rx_used_pct", m_tdata[51:44], want.use_q);
                    check_field("report_valid", 8'(m_tuser[0]), 8'(want.rpt));
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_verdict(s_tuser, s_tdata[2:0], s_tdata[10:3], s_tdata[18:11],
                                has, next_v);
                if (has)
                    verdict_q.push_back(next_v);
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_ACK_ID_OFFSET)
                    ack_ofs = cfg_data;
                else
                    wrap_win = cfg_data[6:0];
            end
            pending = verdict_q.size();
        end
    end

endmodule

// ===== verif/rx_sequence_filter_link_quality_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rx_sequence_filter_link_quality_unit_tb
// drives frame, tx count and report events into the unit under several
// register settings, with random gaps on the input and back-pressure on the output;
// the checker predicts and compares every verdict
// ----------------------------------------------------------------------------
module rx_sequence_filter_link_quality_unit_tb;
    import rsflq_pkg::*;

    localparam int         CLK_HALF       = 2;
    localparam int         RESET_CYCLES   = 8;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         PHASES         = 4;
    localparam int         PHASE_ITEMS    = 500;
    localparam int         HOLD_ITEM      = 100;
    localparam int         HOLD_BURST     = 60;
    localparam logic [2:0] FT_UNKNOWN     = 3'd4;
    localparam logic [2:0] FT_UNKNOWN_TOP = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = CFG_ACK_ID_OFFSET;
    logic [7:0]           cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = KIND_FRAME;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    int         fail_count;
    int         pending;
    int         hold_req = 0;
    int         hold_ack = 0;
    int         win_now;
    logic [7:0] seq_hint [256];

    rx_sequence_filter_link_quality_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rx_seq_filter_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

    // offer one event and hold it until the unit accepts it
    task automatic send_event(input logic [1:0] kind, input logic [2:0] ft,
                              input logic [7:0] ch, input logic [7:0] sq,
                              input bit no_gap);
        int gap;
        int sel;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - 19){1'b0}}, sq, ch, ft};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sel = $urandom_range(0, 99);
        if (no_gap || sel < 65)
            gap = 0;
        else if (sel < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering, let every verdict out, then let a report finish too
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] ofs, input logic [7:0] win_byte);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACK_ID_OFFSET;
        cfg_data  <= ofs;
        @(posedge clk);
        cfg_index <= CFG_WRAP_WINDOW;
        cfg_data  <= win_byte;
        @(posedge clk);
        cfg_we    <= 1'b0;
        win_now = int'(win_byte[6:0]);
    endtask

    // mostly in-order sequences on a few busy channels, with duplicates,
    // late frames around the window edge, jumps and plain noise
    task automatic send_random(input bit no_gap);
        int         sel;
        int         delta;
        int         pick;
        logic [1:0] kind;
        logic [2:0] ft;
        logic [7:0] ch;
        logic [7:0] sq;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            kind = KIND_FRAME;
        else if (sel < 85)
            kind = KIND_TX_ACK;
        else if (sel < 95)
            kind = KIND_TX_RETRY;
        else
            kind = KIND_REPORT;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            ft = FT_ACK;
        else if (sel < 3)
            ft = FT_NO_ACK;
        else if (sel < 5)
            ft = FT_LOW_LAT;
        else if (sel < 8)
            ft = FT_WITH_ACK;
        else
            ft = 3'($urandom_range(FT_UNKNOWN, FT_UNKNOWN_TOP));
        pick = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 7)
            ch = 8'(pick * 85);
        else
            ch = 8'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 40)
            delta = 1;
        else if (sel < 50)
            delta = 0;
        else if (sel < 65)
            delta = -int'($urandom_range(1, win_now + 1));
        else if (sel < 75)
            delta = $urandom_range(2, 40);
        else if (sel < 85)
            delta = -int'($urandom_range(win_now + 1, 255));
        else
            delta = $urandom_range(0, 255);
        sq = seq_hint[ch] + delta[7:0];
        if (kind == KIND_FRAME)
            seq_hint[ch] = sq;
        send_event(kind, ft, ch, sq, no_gap);
    endtask

    // receiver: random ready pattern, plus one long hold-off on request
    initial
    begin : sink
        int sel;
        int n;
        @(posedge clk);
        forever
        begin
            if (hold_req != hold_ack)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_ack = hold_req;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                begin
                    m_tready <= 1'b1;
                    n = $urandom_range(1, 4);
                end
                else if (sel < 90)
                begin
                    m_tready <= 1'b0;
                    n = $urandom_range(1, 3);
                end
                else if (sel < 96)
                begin
                    m_tready <= 1'b1;
                    n = $urandom_range(50, 150);
                end
                else
                begin
                    m_tready <= 1'b0;
                    n = $urandom_range(20, 60);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int ph;
        for (i = 0; i < 256; i++)
            seq_hint[i] = SEQ_RESET;
        win_now = int'(WRAP_WINDOW_RESET);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults
        send_event(KIND_REPORT, FT_ACK, 8'h00, 8'h00, 1'b0);         // nothing counted yet
        send_event(KIND_FRAME, FT_WITH_ACK, 8'h00, 8'h00, 1'b0);     // wraps from reset value
        send_event(KIND_FRAME, FT_WITH_ACK, 8'h00, 8'h00, 1'b0);     // duplicate, still acked
        send_event(KIND_FRAME, FT_NO_ACK, 8'h00, 8'h01, 1'b0);
        send_event(KIND_FRAME, FT_LOW_LAT, 8'h00, 8'h03, 1'b0);      // one missed
        send_event(KIND_FRAME, FT_NO_ACK, 8'h00, 8'h00, 1'b0);       // late, inside window
        send_event(KIND_FRAME, FT_UNKNOWN, 8'hFF, 8'h80, 1'b0);
        send_event(KIND_FRAME, FT_UNKNOWN_TOP, 8'hFF, 8'h81, 1'b0);
        send_event(KIND_FRAME, FT_ACK, 8'h00, 8'h7F, 1'b0);          // moves the table and counts, never delivered
        send_event(KIND_FRAME, FT_NO_ACK, 8'h00, 8'h7F, 1'b0);       // so this one is stale
        send_event(KIND_TX_ACK, FT_UNKNOWN_TOP, 8'hFF, 8'hFF, 1'b0);
        send_event(KIND_TX_ACK, FT_ACK, 8'h00, 8'h00, 1'b0);
        send_event(KIND_TX_RETRY, FT_ACK, 8'h00, 8'h00, 1'b0);
        send_event(KIND_REPORT, FT_ACK, 8'h00, 8'h00, 1'b0);
        send_event(KIND_REPORT, FT_ACK, 8'h00, 8'h00, 1'b0);         // counters just cleared
        drain_block();

        // window zero: any backward step is a wrap; ack channel wraps too
        write_cfg(8'hFF, 8'h00);
        send_event(KIND_FRAME, FT_WITH_ACK, 8'hC8, 8'h10, 1'b0);
        send_event(KIND_FRAME, FT_NO_ACK, 8'hC8, 8'h0F, 1'b0);
        send_event(KIND_REPORT, FT_ACK, 8'h00, 8'h00, 1'b0);
        drain_block();

        // widest window, top data bit set on the window write
        write_cfg(8'h01, 8'hFF);
        send_event(KIND_FRAME, FT_LOW_LAT, 8'h03, 8'h00, 1'b0);
        send_event(KIND_FRAME, FT_LOW_LAT, 8'h03, 8'h81, 1'b0);
        send_event(KIND_FRAME, FT_LOW_LAT, 8'h03, 8'h02, 1'b0);      // just inside window
        send_event(KIND_FRAME, FT_LOW_LAT, 8'h03, 8'h01, 1'b0);      // just beyond it
        send_event(KIND_FRAME, FT_WITH_ACK, 8'hFF, 8'h82, 1'b0);
        send_event(KIND_REPORT, FT_ACK, 8'h00, 8'h00, 1'b0);
        drain_block();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       write_cfg(8'h00, 8'h01);
                1:       write_cfg(8'hFF, 8'h7F);
                2:       write_cfg(8'($urandom), 8'($urandom_range(1, 127)));
                default: write_cfg(8'($urandom), 8'h00);
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 0 && i == PHASE_ITEMS / 2)
                    drain_block();
                if (ph == 1 && i == HOLD_ITEM)
                    hold_req++;
                // keep offering back to back while the receiver holds off
                send_random(ph == 1 && i >= HOLD_ITEM && i < HOLD_ITEM + HOLD_BURST);
            end
            drain_block();
        end

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
